/* sv/teq_pkg.sv */
package teq_pkg;

	localparam int TIME_W          = 48;
	localparam int RCV_W           = 8;
	localparam int TYPE_W          = 16;
	localparam int DELAY_W         = 24;
	localparam int KIND_W          = 2;
	localparam int POLL_W          = 10;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int CNT_W           = $clog2(MAX_RESULTS);

	// APB
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_POLL_INTERVAL = 1'b0;

	localparam logic OP_SCHEDULE = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ACCEPTED   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REJECTED   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DISPATCHED = 2'd2;

	typedef struct packed {
		logic load;         // capture input word, compute due time
		logic sched;        // insert (unless full) and emit schedule answer
		logic tick;         // advance time and poll phase
		logic drain_start;  // clear dispatch count
		logic pop;          // emit head entry and shift row left
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic check;
		logic head_due;
		logic pop_last;
	} dp_status_t;

endpackage

/* sv/timed_event_queue_top.sv */
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    operation, receiver_id, event_type, delay_ticks
// output   out        out_valid / out_ready  kind, out_receiver, out_type, last
// config   APB        psel, penable, pready  paddr, pwdata, prdata (poll_interval at 0x0)
//
// A schedule is captured with the due-time add, then compared and shifted into the cell row.
// A tick advances time and poll phase; a check dispatches each due word (up to 16), or none if none is due.
// A full output register stalls the controller; the next word is taken once it returns to idle.
// Reset clears occupancy, time, poll phase and the output valid; poll_interval resets to 1.
module timed_event_queue_top #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [teq_pkg::RCV_W-1:0]     receiver_id,
	input  logic [teq_pkg::TYPE_W-1:0]    event_type,
	input  logic [teq_pkg::DELAY_W-1:0]   delay_ticks,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [teq_pkg::KIND_W-1:0]    kind,
	output logic [teq_pkg::RCV_W-1:0]     out_receiver,
	output logic [teq_pkg::TYPE_W-1:0]    out_type,
	output logic                          last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [teq_pkg::PADDR_W-1:0]   paddr,
	input  logic [teq_pkg::PDATA_W-1:0]   pwdata,
	output logic [teq_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [teq_pkg::POLL_W-1:0] poll_interval_q;
	logic                       reg_hit;
	teq_pkg::dp_cmd_t           cmd;
	teq_pkg::dp_status_t        status;

	assign pready  = 1'b1;
	assign reg_hit = paddr[teq_pkg::PADDR_W-1:2] == teq_pkg::REG_POLL_INTERVAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_interval_q <= teq_pkg::POLL_W'(1);
		end else if (psel && penable && pwrite && reg_hit) begin
			poll_interval_q <= pwdata[teq_pkg::POLL_W-1:0];
		end
	end

	assign prdata = reg_hit ? teq_pkg::PDATA_W'(poll_interval_q) : '0;

	teq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.status    (status),
		.cmd       (cmd)
	);

	teq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.poll_interval (poll_interval_q),
		.receiver_id   (receiver_id),
		.event_type    (event_type),
		.delay_ticks   (delay_ticks),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_receiver  (out_receiver),
		.out_type      (out_type),
		.last          (last)
	);

endmodule

/* sv/teq_ctrl.sv */
module teq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  teq_pkg::dp_status_t   status,
	output teq_pkg::dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCHED = 4'b0010,
		ST_TICK  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (operation == teq_pkg::OP_TICK) ? ST_TICK : ST_SCHED;
				end
			end
			ST_SCHED: begin
				if (status.out_free) begin
					cmd.sched = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_TICK: begin
				cmd.tick        = 1'b1;
				cmd.drain_start = 1'b1;
				state_d         = status.check ? ST_DRAIN : ST_IDLE;
			end
			ST_DRAIN: begin
				if (!status.head_due) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.pop = 1'b1;
					if (status.pop_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/teq_dp.sv */
module teq_dp #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  teq_pkg::dp_cmd_t             cmd,
	output teq_pkg::dp_status_t          status,
	input  logic [teq_pkg::POLL_W-1:0]   poll_interval,
	input  logic [teq_pkg::RCV_W-1:0]    receiver_id,
	input  logic [teq_pkg::TYPE_W-1:0]   event_type,
	input  logic [teq_pkg::DELAY_W-1:0]  delay_ticks,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [teq_pkg::KIND_W-1:0]   kind,
	output logic [teq_pkg::RCV_W-1:0]    out_receiver,
	output logic [teq_pkg::TYPE_W-1:0]   out_type,
	output logic                         last
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	// input word
	logic [teq_pkg::RCV_W-1:0]  rcv_q;
	logic [teq_pkg::TYPE_W-1:0] type_q;
	logic [teq_pkg::TIME_W-1:0] due_q;

	// sorted cell row, slots below occ_q are live
	logic [teq_pkg::TIME_W-1:0] due_time_q [QUEUE_DEPTH];
	logic [teq_pkg::RCV_W-1:0]  slot_rcv_q [QUEUE_DEPTH];
	logic [teq_pkg::TYPE_W-1:0] slot_type_q[QUEUE_DEPTH];

	logic [OCC_W-1:0]             occ_q;
	logic [teq_pkg::TIME_W-1:0]   now_q;
	logic [teq_pkg::POLL_W-1:0]   phase_q;
	logic [teq_pkg::CNT_W-1:0]    cnt_q;

	logic [QUEUE_DEPTH-1:0]       live;
	logic [QUEUE_DEPTH-1:0]       take;
	logic                         full;
	logic                         do_insert;
	logic [teq_pkg::POLL_W-1:0]   phase_next;
	logic [teq_pkg::POLL_W-1:0]   interval_eff;
	logic                         next_due;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rcv_q  <= receiver_id;
			type_q <= event_type;
			due_q  <= now_q + teq_pkg::TIME_W'(delay_ticks);
		end
	end

	// a cell takes part in the insert shift when it is empty or holds a later due time
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_take
		assign live[i] = OCC_W'(i) < occ_q;
		assign take[i] = !live[i] || (due_time_q[i] > due_q);
	end

	assign full      = occ_q == OCC_W'(QUEUE_DEPTH);
	assign do_insert = cmd.sched && !full;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_insert) begin
					if (take[0]) begin
						due_time_q[0]  <= due_q;
						slot_rcv_q[0]  <= rcv_q;
						slot_type_q[0] <= type_q;
					end
				end else if (cmd.pop) begin
					due_time_q[0]  <= due_time_q[1];
					slot_rcv_q[0]  <= slot_rcv_q[1];
					slot_type_q[0] <= slot_type_q[1];
				end
			end
		end else if (i == QUEUE_DEPTH - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (do_insert) begin
					if (take[i-1]) begin
						due_time_q[i]  <= due_time_q[i-1];
						slot_rcv_q[i]  <= slot_rcv_q[i-1];
						slot_type_q[i] <= slot_type_q[i-1];
					end else if (take[i]) begin
						due_time_q[i]  <= due_q;
						slot_rcv_q[i]  <= rcv_q;
						slot_type_q[i] <= type_q;
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (do_insert) begin
					if (take[i-1]) begin
						due_time_q[i]  <= due_time_q[i-1];
						slot_rcv_q[i]  <= slot_rcv_q[i-1];
						slot_type_q[i] <= slot_type_q[i-1];
					end else if (take[i]) begin
						due_time_q[i]  <= due_q;
						slot_rcv_q[i]  <= rcv_q;
						slot_type_q[i] <= type_q;
					end
				end else if (cmd.pop) begin
					due_time_q[i]  <= due_time_q[i+1];
					slot_rcv_q[i]  <= slot_rcv_q[i+1];
					slot_type_q[i] <= slot_type_q[i+1];
				end
			end
		end
	end

	assign phase_next   = phase_q + 1'b1;
	assign interval_eff = (poll_interval == '0) ? teq_pkg::POLL_W'(1) : poll_interval;
	assign next_due     = live[1] && (due_time_q[1] < now_q);

	always_comb begin
		status.out_free = !out_valid || out_ready;
		status.check    = !((phase_next < interval_eff) && (phase_next != '0));
		status.head_due = live[0] && (due_time_q[0] < now_q);
		status.pop_last = (cnt_q == teq_pkg::CNT_W'(teq_pkg::MAX_RESULTS - 1)) || !next_due;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			now_q   <= '0;
			phase_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (do_insert) begin
				occ_q <= occ_q + 1'b1;
			end else if (cmd.pop) begin
				occ_q <= occ_q - 1'b1;
			end
			if (cmd.tick) begin
				now_q   <= now_q + 1'b1;
				phase_q <= status.check ? '0 : phase_next;
			end
			if (cmd.drain_start) begin
				cnt_q <= '0;
			end else if (cmd.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.sched || cmd.pop) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sched) begin
			kind         <= full ? teq_pkg::KIND_REJECTED : teq_pkg::KIND_ACCEPTED;
			out_receiver <= rcv_q;
			out_type     <= type_q;
			last         <= 1'b1;
		end else if (cmd.pop) begin
			kind         <= teq_pkg::KIND_DISPATCHED;
			out_receiver <= slot_rcv_q[0];
			out_type     <= slot_type_q[0];
			last         <= status.pop_last;
		end
	end

endmodule
